@@ hw/rtl/gfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// gfrs_pkg
// Shared types and constants of the reflect-padded FIR smoother.
// ----------------------------------------------------------------------------
package gfrs_pkg;

	// fixed field and register widths
	localparam int IDX_BITS  = 6;
	localparam int HW_BITS   = 5;
	localparam int SEEN_BITS = 16;

	localparam logic [HW_BITS-1:0] HW_RESET = 5'd9;

	// kind of an input item, carried on tuser
	localparam logic MODE_WEIGHT = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// marks that travel with each tap down the multiply-accumulate path
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} tap_tag_t;

	// result request from the sequencer to the output register
	typedef struct packed {
		logic vld;
		logic last;
		logic too_short;
	} emit_t;

endpackage

@@ hw/rtl/gfrs_store.sv @@
// ----------------------------------------------------------------------------
// gfrs_store
// Sample ring and tap weight memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module gfrs_store #(
	parameter int SAMPLE_BITS = 32,
	parameter int WEIGHT_BITS = 16,
	parameter int DEPTH       = 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ring_we,
	input  logic [$clog2(DEPTH)-1:0]      ring_waddr,
	input  logic [SAMPLE_BITS-1:0]        ring_wdata,
	input  logic                          wgt_we,
	input  logic [$clog2(DEPTH)-1:0]      wgt_waddr,
	input  logic [WEIGHT_BITS-1:0]        wgt_wdata,
	input  logic [$clog2(DEPTH)-1:0]      ring_raddr,
	input  logic [$clog2(DEPTH)-1:0]      wgt_raddr,
	input  gfrs_pkg::tap_tag_t            tag,
	output logic signed [SAMPLE_BITS-1:0] smp_s1,
	output logic [WEIGHT_BITS-1:0]        wgt_s1,
	output gfrs_pkg::tap_tag_t            tag_s1
);

	logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
	logic [WEIGHT_BITS-1:0] wgt_mem  [DEPTH];

	// write and read the sample ring
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		smp_s1 <= $signed(ring_mem[ring_raddr]);
	end

	// write and read the tap weights
	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wgt_waddr] <= wgt_wdata;
		end
		wgt_s1 <= wgt_mem[wgt_raddr];
	end

	// carry the tap marks alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

endmodule

@@ hw/rtl/gfrs_mac.sv @@
// ----------------------------------------------------------------------------
// gfrs_mac
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module gfrs_mac #(
	parameter int SAMPLE_BITS = 32,
	parameter int WEIGHT_BITS = 16,
	parameter int GUARD_BITS  = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gfrs_pkg::tap_tag_t            tag_s1,
	input  logic signed [SAMPLE_BITS-1:0] smp_s1,
	input  logic [WEIGHT_BITS-1:0]        wgt_s1,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int ACC_W  = PROD_W + GUARD_BITS;

	logic signed [PROD_W-1:0] prod_s2;
	gfrs_pkg::tap_tag_t       tag_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     done_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  quo;
	logic                     fits;

	// multiply sample by zero-extended weight
	always_ff @(posedge clk) begin
		prod_s2 <= smp_s1 * $signed({1'b0, wgt_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			done_q <= tag_s2.vld && tag_s2.last;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);

	// accumulate, restarting on the first tap of an output
	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			if (tag_s2.first) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	// round half up, drop the weight fraction, saturate to the sample range
	always_comb begin
		rnd  = acc_q + $signed(ACC_W'(1) << (WEIGHT_BITS - 1));
		quo  = rnd >>> WEIGHT_BITS;
		fits = (&quo[ACC_W-1:SAMPLE_BITS-1]) || !(|quo[ACC_W-1:SAMPLE_BITS-1]);
		if (fits) begin
			result = quo[SAMPLE_BITS-1:0];
		end else if (quo[ACC_W-1]) begin
			result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule

@@ hw/rtl/gfrs_seq.sv @@
// ----------------------------------------------------------------------------
// gfrs_seq
// Sequencer: ring bookkeeping, mirrored tap addressing and result control.
// ----------------------------------------------------------------------------
module gfrs_seq #(
	parameter int MAX_HALF_WIDTH = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_vld,
	output logic                                            in_rdy,
	input  logic                                            in_mode,
	input  logic [gfrs_pkg::IDX_BITS-1:0]                   in_idx,
	input  logic                                            in_eos,
	input  logic [gfrs_pkg::HW_BITS-1:0]                    hw,
	output logic                                            ring_we,
	output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]           ring_waddr,
	output logic                                            wgt_we,
	output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]           wgt_waddr,
	output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]           ring_raddr,
	output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]           wgt_raddr,
	output gfrs_pkg::tap_tag_t                              tag,
	input  logic                                            mac_done,
	output gfrs_pkg::emit_t                                 emit,
	input  logic                                            emit_take
);

	localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = AW + 2;
	localparam int SB    = gfrs_pkg::SEEN_BITS;
	localparam int HB    = gfrs_pkg::HW_BITS;

	gfrs_pkg::state_t state_q, state_d;
	logic [AW-1:0]    head_q, head_d;
	logic [SB-1:0]    seen_q, seen_d;
	logic [AW-1:0]    slim_q, slim_d;
	logic [HB-1:0]    d_q, d_d;
	logic [AW-1:0]    t_q, t_d;
	logic             flush_q, flush_d;
	logic             short_q, short_d;

	logic             accept;
	logic [SB-1:0]    s_cur;
	logic [SB-1:0]    seen_inc;
	logic [AW-1:0]    head_inc;
	logic signed [SW-1:0] a_s;
	logic signed [SW-1:0] slim_s;
	logic signed [SW-1:0] age_s;
	logic signed [SW-1:0] addr_s;
	logic [AW-1:0]    age_u;

	assign in_rdy = (state_q == gfrs_pkg::ST_IDLE);
	assign accept = in_vld && in_rdy;

	// position of the newest sample, counted from the start of the stream
	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + SB'(1);
	assign s_cur    = seen_inc - SB'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// store writes on transfer
	assign ring_we    = accept && (in_mode == gfrs_pkg::MODE_SAMPLE);
	assign ring_waddr = head_q;
	assign wgt_we     = accept && (in_mode == gfrs_pkg::MODE_WEIGHT) &&
		(in_idx < gfrs_pkg::IDX_BITS'(DEPTH));
	assign wgt_waddr  = in_idx[AW-1:0];

	// mirrored age of the current tap relative to the newest sample
	always_comb begin
		a_s    = $signed(SW'(d_q) + SW'(hw) - SW'(t_q));
		slim_s = $signed(SW'(slim_q));
		if (a_s > slim_s) begin
			age_s = (slim_s <<< 1) - a_s;
		end else if (a_s < 0) begin
			age_s = -a_s;
		end else begin
			age_s = a_s;
		end
		age_u  = age_s[AW-1:0];
		addr_s = $signed(SW'(head_q) - SW'(1) - SW'(age_u));
		if (addr_s < 0) begin
			addr_s = addr_s + $signed(SW'(DEPTH));
		end
	end

	assign ring_raddr = addr_s[AW-1:0];
	assign wgt_raddr  = t_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			seen_q  <= '0;
			slim_q  <= '0;
			d_q     <= '0;
			t_q     <= '0;
			flush_q <= 1'b0;
			short_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			seen_q  <= seen_d;
			slim_q  <= slim_d;
			d_q     <= d_d;
			t_q     <= t_d;
			flush_q <= flush_d;
			short_q <= short_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		seen_d  = seen_q;
		slim_d  = slim_q;
		d_d     = d_q;
		t_d     = t_q;
		flush_d = flush_q;
		short_d = short_q;

		tag.vld   = (state_q == gfrs_pkg::ST_ISSUE);
		tag.first = (t_q == '0);
		tag.last  = (t_q == (AW'(hw) << 1));

		emit.vld       = (state_q == gfrs_pkg::ST_EMIT);
		emit.last      = flush_q && (short_q || (d_q == '0));
		emit.too_short = short_q;

		case (state_q)
			gfrs_pkg::ST_IDLE: begin
				if (ring_we) begin
					head_d = head_inc;
					slim_d = (s_cur > SB'(DEPTH)) ? AW'(DEPTH) : s_cur[AW-1:0];
					d_d    = hw;
					t_d    = '0;
					if (in_eos) begin
						seen_d  = '0;
						flush_d = 1'b1;
						if (s_cur < SB'(hw)) begin
							short_d = 1'b1;
							state_d = gfrs_pkg::ST_EMIT;
						end else begin
							short_d = 1'b0;
							state_d = gfrs_pkg::ST_ISSUE;
						end
					end else begin
						seen_d  = seen_inc;
						flush_d = 1'b0;
						short_d = 1'b0;
						if (s_cur >= SB'(hw)) begin
							state_d = gfrs_pkg::ST_ISSUE;
						end
					end
				end
			end
			gfrs_pkg::ST_ISSUE: begin
				// step one tap per cycle through the shared unit
				t_d = t_q + AW'(1);
				if (tag.last) begin
					state_d = gfrs_pkg::ST_DRAIN;
				end
			end
			gfrs_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_d = gfrs_pkg::ST_EMIT;
				end
			end
			gfrs_pkg::ST_EMIT: begin
				if (emit_take) begin
					if (flush_q && !short_q && (d_q != '0)) begin
						d_d     = d_q - HB'(1);
						t_d     = '0;
						state_d = gfrs_pkg::ST_ISSUE;
					end else begin
						state_d = gfrs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = gfrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/gaussian_fir_reflect_smoother.sv @@
// ----------------------------------------------------------------------------
// gaussian_fir_reflect_smoother
// Symmetric FIR smoother with mirror padding at both ends of a sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wen/cfg_wdata write half_width (taps each side of centre, reset 9,
//   values above MAX_HALF_WIDTH act as MAX_HALF_WIDTH); write it while idle.
//   s_axis: tuser 0 loads one Q0.16 tap weight (index, value); tuser 1
//   delivers one sample, tlast marks the final sample of the stream.
//   m_axis: one smoothed sample per output, tlast on the final output of a
//   flush, tuser flags a stream no longer than half_width (data zero).
// Operation (hw = effective half_width):
//   a weight load or an early sample is taken in one transfer; a sample that
//   gives an output steps 2*hw+1 taps through the single multiplier, then
//   through the read, product and accumulate stages, hands the result to
//   the output register and returns to idle; the final sample of a stream
//   longer than half_width gives hw+1 outputs in turn.
//   s_axis_tready is low while an item is in work.
// Reset sets half_width to 9 and clears the stream position and the output valid;
// weight and sample memories are not cleared and must be loaded first.
// A stalled receiver holds the result register; the sequencer waits for it.
// ----------------------------------------------------------------------------
module gaussian_fir_reflect_smoother #(
	parameter int MAX_HALF_WIDTH = 16,
	parameter int SAMPLE_BITS    = 32,
	parameter int WEIGHT_BITS    = 16,
	localparam int IN_W  = ((gfrs_pkg::IDX_BITS + WEIGHT_BITS + SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [gfrs_pkg::HW_BITS-1:0] cfg_wdata,     // half_width
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [IN_W-1:0]              s_axis_tdata,  // weight_index, weight_value, sample_value
	input  logic                         s_axis_tuser,  // mode
	input  logic                         s_axis_tlast,  // end_of_stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [OUT_W-1:0]             m_axis_tdata,  // smoothed_value
	output logic                         m_axis_tuser,  // too_short
	output logic                         m_axis_tlast   // last_result
);

	localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int IB    = gfrs_pkg::IDX_BITS;
	localparam int HB    = gfrs_pkg::HW_BITS;

	logic [HB-1:0]                hw_q;
	logic [HB-1:0]                hw_eff;
	logic [IB-1:0]                in_idx;
	logic [WEIGHT_BITS-1:0]       in_wgt;
	logic [SAMPLE_BITS-1:0]       in_smp;

	logic                         ring_we;
	logic [AW-1:0]                ring_waddr;
	logic                         wgt_we;
	logic [AW-1:0]                wgt_waddr;
	logic [AW-1:0]                ring_raddr;
	logic [AW-1:0]                wgt_raddr;
	gfrs_pkg::tap_tag_t           tag;
	gfrs_pkg::tap_tag_t           tag_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [WEIGHT_BITS-1:0]       wgt_s1;
	logic                         mac_done;
	logic signed [SAMPLE_BITS-1:0] mac_result;
	gfrs_pkg::emit_t              emit;
	logic                         emit_take;
	logic                         out_free;

	logic                         out_vld_q;
	logic [SAMPLE_BITS-1:0]       out_data_q;
	logic                         out_last_q;
	logic                         out_short_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= gfrs_pkg::HW_RESET;
		end else if (cfg_wen) begin
			hw_q <= cfg_wdata;
		end
	end

	// clamp half_width to the built MAX_HALF_WIDTH
	assign hw_eff = (hw_q > HB'(MAX_HALF_WIDTH)) ? HB'(MAX_HALF_WIDTH) : hw_q;

	// unpack the input transfer
	assign in_idx = s_axis_tdata[IB-1:0];
	assign in_wgt = s_axis_tdata[IB +: WEIGHT_BITS];
	assign in_smp = s_axis_tdata[IB + WEIGHT_BITS +: SAMPLE_BITS];

	gfrs_seq #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (s_axis_tvalid),
		.in_rdy     (s_axis_tready),
		.in_mode    (s_axis_tuser),
		.in_idx     (in_idx),
		.in_eos     (s_axis_tlast),
		.hw         (hw_eff),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.wgt_we     (wgt_we),
		.wgt_waddr  (wgt_waddr),
		.ring_raddr (ring_raddr),
		.wgt_raddr  (wgt_raddr),
		.tag        (tag),
		.mac_done   (mac_done),
		.emit       (emit),
		.emit_take  (emit_take)
	);

	gfrs_store #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.DEPTH      (DEPTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (in_smp),
		.wgt_we     (wgt_we),
		.wgt_waddr  (wgt_waddr),
		.wgt_wdata  (in_wgt),
		.ring_raddr (ring_raddr),
		.wgt_raddr  (wgt_raddr),
		.tag        (tag),
		.smp_s1     (smp_s1),
		.wgt_s1     (wgt_s1),
		.tag_s1     (tag_s1)
	);

	gfrs_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.GUARD_BITS (AW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (tag_s1),
		.smp_s1 (smp_s1),
		.wgt_s1 (wgt_s1),
		.done   (mac_done),
		.result (mac_result)
	);

	// output register: load when empty or being drained
	assign out_free  = !out_vld_q || m_axis_tready;
	assign emit_take = emit.vld && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= emit.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_data_q  <= emit.too_short ? '0 : mac_result;
			out_last_q  <= emit.last;
			out_short_q <= emit.too_short;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_short_q;

endmodule

@@ hw/rtl/gfrs_checker.sv @@
// ----------------------------------------------------------------------------
// gfrs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module gfrs_checker #(
	parameter int OUT_W = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             s_axis_tuser,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tuser,
	input logic             m_axis_tlast
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a short-stream result is a zero final result
	a_short_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("short-stream result not final or not zero");

	// a weight load leaves the block ready
	a_weight_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_axis_tuser == gfrs_pkg::MODE_WEIGHT) |=> s_axis_tready)
		else $error("busy after weight load");

	// the final sample always starts a flush
	a_eos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_axis_tuser == gfrs_pkg::MODE_SAMPLE) && s_axis_tlast |=> !s_axis_tready)
		else $error("final sample gave no flush");

endmodule

bind gaussian_fir_reflect_smoother gfrs_checker #(
	.OUT_W(OUT_W)
) u_gfrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
